[design/rpfm_pkg.sv]
// shared constants and types for the rolling power fourth-mean block
`timescale 1ns / 1ps

package rpfm_pkg;

   // defaults for the top-level parameters
   localparam int MAX_WINDOW_DEF = 256;
   localparam int POWER_BITS_DEF = 12;

   // fixed field widths
   localparam int SAMPLE_W    = 13;
   localparam int CFG_W       = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int OUT_W       = 16;
   localparam int TOTAL_W     = 64;
   localparam int ACOUNT_W    = 32;
   localparam int VCNT_W      = CFG_W + 1;
   localparam int ROOT_SQ_W   = 2 * OUT_W;
   localparam int ROOT_BIT_W  = $clog2(OUT_W);
   localparam int DCNT_W      = $clog2(TOTAL_W + 1);
   localparam int FRAC_SHIFT  = 4 * 4;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP     = CSR_IDX_W'(1);

   // register reset values
   localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = CFG_W'(25);
   localparam logic [CFG_W-1:0] WARMUP_RESET     = CFG_W'(25);

endpackage

[design/rolling_power_fourth_mean.sv]
// top level: rolling power average, fourth-power mean and fourth root
`timescale 1ns / 1ps

// Takes one power sample per item and returns a result only on the item that
// carries end_of_ride. A valid sample is read from and written to the window;
// once past warmup it forms a rounded window average in SUM_W+1 divider steps,
// and the shift-add multiplier squares the average and then squares the
// square, stopping when the multiplier operand runs out of set bits. The end
// of a ride adds 64 divider steps for the mean and 16 root trials, each a
// square, a fourth power and a compare. All of this work is done in one
// bit-per-cycle restoring divider and one bit-per-cycle shift-add multiplier
// under a small sequencer; req_ready is low while they run. A finished result
// waits in an output register while the next item is taken. Window entries
// are tracked by a fill count, so there is no clearing pass after reset or at
// the end of a ride.
module rolling_power_fourth_mean
   import rpfm_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int POWER_BITS = POWER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_sample_power,
   input  logic                   req_end_of_ride,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_W-1:0]       rsp_weighted_power,
   output logic                   rsp_no_average,
   output logic                   rsp_sum_saturated,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int IDX_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FILL_W    = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W     = POWER_BITS + $clog2(MAX_WINDOW);
   localparam int NUM_W     = SUM_W + 1;
   localparam int MB_W      = (2 * SUM_W > ROOT_SQ_W) ? 2 * SUM_W : ROOT_SQ_W;
   localparam int POWER_MAX = (1 << POWER_BITS) - 1;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_READ     = 13'b0000000000010,
      S_PREP     = 13'b0000000000100,
      S_DIV_AVG  = 13'b0000000001000,
      S_MUL_SQ   = 13'b0000000010000,
      S_MUL_P4   = 13'b0000000100000,
      S_ACCUM    = 13'b0000001000000,
      S_FINISH   = 13'b0000010000000,
      S_DIV_MEAN = 13'b0000100000000,
      S_ROOT_SQ  = 13'b0001000000000,
      S_ROOT_P4  = 13'b0010000000000,
      S_ROOT_CMP = 13'b0100000000000,
      S_EMIT     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]      window_len_ff, window_len_in;
   logic [CFG_W-1:0]      warmup_ff, warmup_in;

   logic [POWER_BITS-1:0] sample_ff, sample_in;
   logic                  last_ff, last_in;
   logic [POWER_BITS-1:0] window_mem [MAX_WINDOW];
   logic [POWER_BITS-1:0] rd_data_ff;
   logic                  mem_re, mem_we;

   logic [IDX_W-1:0]      write_idx_ff, write_idx_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [VCNT_W-1:0]     vcnt_ff, vcnt_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [ACOUNT_W-1:0]   acount_ff, acount_in;
   logic                  sat_ff, sat_in;

   // shared divider
   logic [TOTAL_W-1:0]    num_ff, num_in;
   logic [ACOUNT_W-1:0]   rem_ff, rem_in;
   logic [ACOUNT_W-1:0]   divisor_ff, divisor_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;

   // shared multiplier
   logic [TOTAL_W-1:0]    mcand_ff, mcand_in;
   logic [MB_W-1:0]       mplier_ff, mplier_in;
   logic [TOTAL_W-1:0]    acc_ff, acc_in;

   // root search
   logic [OUT_W-1:0]      root_ff, root_in;
   logic [ROOT_BIT_W-1:0] bit_ff, bit_in;
   logic                  noavg_ff, noavg_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_weight_ff, rsp_weight_in;
   logic                  rsp_noavg_ff, rsp_noavg_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   // combinational helpers
   logic [CFG_W-1:0]      eff_len;
   logic [POWER_BITS-1:0] clip_sample;
   logic [POWER_BITS-1:0] old_val;
   logic [SUM_W-1:0]      sum_next;
   logic [VCNT_W-1:0]     vcnt_next;
   logic [ACOUNT_W:0]     div_trial;
   logic                  div_ge;
   logic [TOTAL_W:0]      total_sum;
   logic                  root_fits;
   logic [OUT_W-1:0]      root_next;
   logic [OUT_W-1:0]      trial_val;
   logic                  req_fire;
   logic                  out_free;

   assign req_ready          = (state_ff == S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_weighted_power = rsp_weight_ff;
   assign rsp_no_average     = rsp_noavg_ff;
   assign rsp_sum_saturated  = rsp_sat_ff;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // window length as used: zero acts as one, clipped to the store depth
   always_comb begin
      if (window_len_ff == '0) begin
         eff_len = CFG_W'(1);
      end else if (32'(window_len_ff) > MAX_WINDOW) begin
         eff_len = CFG_W'(MAX_WINDOW);
      end else begin
         eff_len = window_len_ff;
      end
   end

   always_comb begin
      if (32'(req_sample_power[SAMPLE_W-2:0]) > POWER_MAX) begin
         clip_sample = POWER_BITS'(POWER_MAX);
      end else begin
         clip_sample = POWER_BITS'(req_sample_power[SAMPLE_W-2:0]);
      end
   end

   // entries at or beyond the fill count were not written this ride
   assign old_val   = (32'(write_idx_ff) < 32'(fill_ff)) ? rd_data_ff : '0;
   assign sum_next  = sum_ff - SUM_W'(old_val) + SUM_W'(sample_ff);
   assign vcnt_next = (vcnt_ff == '1) ? vcnt_ff : vcnt_ff + VCNT_W'(1);

   assign div_trial = {rem_ff, num_ff[TOTAL_W-1]};
   assign div_ge    = div_trial >= {1'b0, divisor_ff};

   assign total_sum = {1'b0, total_ff} + {1'b0, acc_ff};

   assign root_fits = TOTAL_W'(acc_ff[TOTAL_W-1:FRAC_SHIFT]) <= num_ff;
   assign root_next = root_fits ? (root_ff | (OUT_W'(1) << bit_ff)) : root_ff;
   assign trial_val = root_next | (OUT_W'(1) << (bit_ff - ROOT_BIT_W'(1)));

   always_comb begin
      state_in       = state_ff;
      window_len_in  = window_len_ff;
      warmup_in      = warmup_ff;
      sample_in      = sample_ff;
      last_in        = last_ff;
      mem_re         = 1'b0;
      mem_we         = 1'b0;
      write_idx_in   = write_idx_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      vcnt_in        = vcnt_ff;
      total_in       = total_ff;
      acount_in      = acount_ff;
      sat_in         = sat_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      dcnt_in        = dcnt_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      acc_in         = acc_ff;
      root_in        = root_ff;
      bit_in         = bit_ff;
      noavg_in       = noavg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_weight_in  = rsp_weight_ff;
      rsp_noavg_in   = rsp_noavg_ff;
      rsp_sat_in     = rsp_sat_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_LEN: window_len_in = csr_wdata;
            CSR_WARMUP:     warmup_in = csr_wdata;
            default: ;
         endcase
      end

      // one divider step per cycle while the count runs
      if ((state_ff == S_DIV_AVG || state_ff == S_DIV_MEAN) && dcnt_ff != '0) begin
         rem_in  = div_ge ? ACOUNT_W'(div_trial - {1'b0, divisor_ff})
                          : div_trial[ACOUNT_W-1:0];
         num_in  = {num_ff[TOTAL_W-2:0], div_ge};
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end

      // one multiplier bit per cycle until the multiplier runs out
      if ((state_ff == S_MUL_SQ || state_ff == S_MUL_P4 ||
           state_ff == S_ROOT_SQ || state_ff == S_ROOT_P4) && mplier_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sample_in = clip_sample;
               last_in   = req_end_of_ride;
               if (!req_sample_power[SAMPLE_W-1]) begin
                  mem_re   = 1'b1;
                  state_in = S_READ;
               end else if (req_end_of_ride) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_READ: begin
            mem_we  = 1'b1;
            sum_in  = sum_next;
            vcnt_in = vcnt_next;
            if (32'(write_idx_ff) == 32'(fill_ff)) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            if (32'(write_idx_ff) + 1 >= 32'(eff_len)) begin
               write_idx_in = '0;
            end else begin
               write_idx_in = write_idx_ff + IDX_W'(1);
            end
            if (32'(vcnt_next) > 32'(warmup_ff)) begin
               state_in = S_PREP;
            end else if (last_ff) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PREP: begin
            // rounded average: (sum + len/2) / len, numerator aligned to the top
            num_in     = (TOTAL_W'(sum_ff) + TOTAL_W'(eff_len >> 1)) << (TOTAL_W - NUM_W);
            rem_in     = '0;
            divisor_in = ACOUNT_W'(eff_len);
            dcnt_in    = DCNT_W'(NUM_W);
            state_in   = S_DIV_AVG;
         end
         S_DIV_AVG: begin
            if (dcnt_ff == '0) begin
               mcand_in  = TOTAL_W'(num_ff[SUM_W-1:0]);
               mplier_in = MB_W'(num_ff[SUM_W-1:0]);
               acc_in    = '0;
               state_in  = S_MUL_SQ;
            end
         end
         S_MUL_SQ: begin
            if (mplier_ff == '0) begin
               mcand_in  = acc_ff;
               mplier_in = MB_W'(acc_ff);
               acc_in    = '0;
               state_in  = S_MUL_P4;
            end
         end
         S_MUL_P4: begin
            if (mplier_ff == '0) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (total_sum[TOTAL_W]) begin
               total_in = '1;
               sat_in   = 1'b1;
            end else begin
               total_in = total_sum[TOTAL_W-1:0];
            end
            if (acount_ff != '1) begin
               acount_in = acount_ff + ACOUNT_W'(1);
            end
            state_in = last_ff ? S_FINISH : S_IDLE;
         end
         S_FINISH: begin
            if (acount_ff == '0) begin
               root_in  = '0;
               noavg_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               num_in     = total_ff;
               rem_in     = '0;
               divisor_in = acount_ff;
               dcnt_in    = DCNT_W'(TOTAL_W);
               state_in   = S_DIV_MEAN;
            end
         end
         S_DIV_MEAN: begin
            if (dcnt_ff == '0) begin
               root_in   = '0;
               noavg_in  = 1'b0;
               bit_in    = ROOT_BIT_W'(OUT_W - 1);
               mcand_in  = TOTAL_W'(OUT_W'(1) << (OUT_W - 1));
               mplier_in = MB_W'(OUT_W'(1) << (OUT_W - 1));
               acc_in    = '0;
               state_in  = S_ROOT_SQ;
            end
         end
         S_ROOT_SQ: begin
            if (mplier_ff == '0) begin
               mcand_in  = acc_ff;
               mplier_in = MB_W'(acc_ff[ROOT_SQ_W-1:0]);
               acc_in    = '0;
               state_in  = S_ROOT_P4;
            end
         end
         S_ROOT_P4: begin
            if (mplier_ff == '0) begin
               state_in = S_ROOT_CMP;
            end
         end
         S_ROOT_CMP: begin
            root_in = root_next;
            if (bit_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               bit_in    = bit_ff - ROOT_BIT_W'(1);
               mcand_in  = TOTAL_W'(trial_val);
               mplier_in = MB_W'(trial_val);
               acc_in    = '0;
               state_in  = S_ROOT_SQ;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = root_ff;
               rsp_noavg_in  = noavg_ff;
               rsp_sat_in    = sat_ff;
               // ride state clears for the next ride
               write_idx_in  = '0;
               fill_in       = '0;
               sum_in        = '0;
               vcnt_in       = '0;
               total_in      = '0;
               acount_in     = '0;
               sat_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[write_idx_ff] <= sample_ff;
      end
      if (mem_re) begin
         rd_data_ff <= window_mem[write_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         window_len_ff <= WINDOW_LEN_RESET;
         warmup_ff     <= WARMUP_RESET;
         write_idx_ff  <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         vcnt_ff       <= '0;
         total_ff      <= '0;
         acount_ff     <= '0;
         sat_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         warmup_ff     <= warmup_in;
         write_idx_ff  <= write_idx_in;
         fill_ff       <= fill_in;
         sum_ff        <= sum_in;
         vcnt_ff       <= vcnt_in;
         total_ff      <= total_in;
         acount_ff     <= acount_in;
         sat_ff        <= sat_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      last_ff       <= last_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      dcnt_ff       <= dcnt_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      acc_ff        <= acc_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      noavg_ff      <= noavg_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_noavg_ff  <= rsp_noavg_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

endmodule

[design/rpfm_checker.sv]
// port-level checks for the rolling power fourth-mean block, bound to the top
`timescale 1ns / 1ps

module rpfm_checker
   import rpfm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [SAMPLE_W-1:0]  req_sample_power,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUT_W-1:0]     rsp_weighted_power,
   input logic                 rsp_no_average,
   input logic                 rsp_sum_saturated
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weighted_power)
         && $stable(rsp_no_average) && $stable(rsp_sum_saturated))
      else $error("stalled result changed");

   // a ride without an average reports zero power
   a_noavg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_average |-> rsp_weighted_power == '0)
      else $error("no-average result carries nonzero power");

   // a present sample keeps the block busy for at least the next cycle
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_sample_power[SAMPLE_W-1] |=> !req_ready)
      else $error("ready right after a present sample");

   // a new result only comes out of a busy sequencer
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while the block was idle");

endmodule

bind rolling_power_fourth_mean rpfm_checker u_rpfm_checker (.*);

[tb/tb_rolling_power_fourth_mean.sv]
// testbench for the rolling power fourth-mean block with a ride result scoreboard
`timescale 1ns / 1ps

module tb_rolling_power_fourth_mean;
   import rpfm_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 5;
   localparam int POWER_MAX     = (1 << POWER_BITS_DEF) - 1;
   localparam int RANDOM_ITEMS  = 850;
   localparam int HOLD_PHASE    = 3;
   localparam int HOLD_CYCLES   = 3000;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 10000000;

   // indexes outside the register map, the block must ignore them
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_HI = CSR_IDX_W'(3);

   localparam logic [SAMPLE_W-1:0] MISSING_LOWEST = 13'h1000;
   localparam logic [SAMPLE_W-1:0] MISSING_ONE    = 13'h1fff;

   typedef struct packed {
      logic [OUT_W-1:0] weighted_power;
      logic             no_average;
      logic             sum_saturated;
   } ride_result_type;

   // tracks one ride of samples and the results still owed by the block
   class ride_ledger_type;
      int unsigned       window_mem [MAX_WINDOW_DEF];
      int unsigned       wr_idx;
      int unsigned       win_sum;
      int unsigned       valid_cnt;
      int unsigned       avg_cnt;
      longint unsigned   fourth_total;
      bit                sat;
      int unsigned       window_len;
      int unsigned       warmup;
      ride_result_type   awaited_results [$];
      int unsigned       errors;

      function new();
         window_len = WINDOW_LEN_RESET;
         warmup     = WARMUP_RESET;
         errors     = 0;
         clear_ride();
      endfunction

      function void clear_ride();
         foreach (window_mem[i]) window_mem[i] = 0;
         wr_idx       = 0;
         win_sum      = 0;
         valid_cnt    = 0;
         avg_cnt      = 0;
         fourth_total = 0;
         sat          = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_WINDOW_LEN: window_len = data;
            CSR_WARMUP:     warmup = data;
            default: ;
         endcase
      endfunction

      function void take_sample(logic [SAMPLE_W-1:0] power, logic eor);
         int unsigned     len;
         int unsigned     w;
         int unsigned     idx;
         longint unsigned avg;
         longint unsigned p;
         longint unsigned m;
         longint unsigned r;
         longint unsigned t;
         ride_result_type res;
         len = (window_len == 0) ? 1 :
               (window_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : window_len;
         if (!power[SAMPLE_W-1]) begin
            w = power;
            if (w > POWER_MAX) w = POWER_MAX;
            idx = wr_idx;
            if (valid_cnt != 32'hffff_ffff) valid_cnt++;
            win_sum = win_sum - window_mem[idx] + w;
            window_mem[idx] = w;
            if (valid_cnt > warmup) begin
               avg = (64'(win_sum) + 64'(len >> 1)) / 64'(len);
               p = avg * avg;
               p = p * p;
               if (fourth_total > 64'hffff_ffff_ffff_ffff - p) begin
                  fourth_total = 64'hffff_ffff_ffff_ffff;
                  sat = 1'b1;
               end else begin
                  fourth_total += p;
               end
               if (avg_cnt != 32'hffff_ffff) avg_cnt++;
            end
            wr_idx = (idx + 1 >= len) ? 0 : idx + 1;
         end
         if (eor) begin
            if (avg_cnt == 0) begin
               res.weighted_power = '0;
               res.no_average     = 1'b1;
            end else begin
               // bitwise search for the largest r with r^4 / 2^16 <= mean
               m = fourth_total / 64'(avg_cnt);
               r = 0;
               for (int b = OUT_W - 1; b >= 0; b--) begin
                  t = r | (64'd1 << b);
                  p = t * t;
                  p = p * p;
                  if ((p >> FRAC_SHIFT) <= m) r = t;
               end
               res.weighted_power = r[OUT_W-1:0];
               res.no_average     = 1'b0;
            end
            res.sum_saturated = sat;
            awaited_results.push_back(res);
            clear_ride();
         end
      endfunction

      function void match_result(logic [OUT_W-1:0] wp, logic na, logic ss);
         ride_result_type want;
         if (awaited_results.size() == 0) begin
            $error("unexpected result: weighted_power %0d no_average %0b sum_saturated %0b",
                   wp, na, ss);
            errors++;
            return;
         end
         want = awaited_results.pop_front();
         if (wp !== want.weighted_power) begin
            $error("weighted_power mismatch: expected %0d, actual %0d", want.weighted_power, wp);
            errors++;
         end
         if (na !== want.no_average) begin
            $error("no_average mismatch: expected %0b, actual %0b", want.no_average, na);
            errors++;
         end
         if (ss !== want.sum_saturated) begin
            $error("sum_saturated mismatch: expected %0b, actual %0b", want.sum_saturated, ss);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_sample_power;
   logic                 req_end_of_ride;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [OUT_W-1:0]     rsp_weighted_power;
   logic                 rsp_no_average;
   logic                 rsp_sum_saturated;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   ride_ledger_type ledger = new();
   int unsigned cycle_count = 0;
   int          items_sent = 0;
   int          req_calm = 0;
   int          rsp_calm = 0;
   bit          hold_off = 1'b0;

   rolling_power_fourth_mean dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_power   (req_sample_power),
      .req_end_of_ride    (req_end_of_ride),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_weighted_power (rsp_weighted_power),
      .rsp_no_average     (rsp_no_average),
      .rsp_sum_saturated  (rsp_sum_saturated),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // random idle length, with occasional stretches of back-to-back traffic
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   function automatic logic [SAMPLE_W-1:0] valid_power();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return SAMPLE_W'(POWER_MAX);
         default: return SAMPLE_W'($urandom_range(0, POWER_MAX));
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] missing_power();
      return {1'b1, 12'($urandom)};
   endfunction

   task automatic send_item(input logic [SAMPLE_W-1:0] power, input logic eor);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_power <= power;
      req_end_of_ride  <= eor;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.take_sample(power, eor);
      items_sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ledger.write_reg(idx, data);
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic program_regs(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] warm);
      csr_write(CSR_WINDOW_LEN, len, 1'b0);
      csr_write(CSR_WARMUP, warm, 1'b1);
   endtask

   // block idle: nothing owed, and time for a sample without a result to finish
   task automatic quiesce();
      req_valid <= 1'b0;
      while (ledger.awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_ride(input int n_valid);
      bit tail_missing;
      tail_missing = (n_valid == 0) || ($urandom_range(0, 5) == 0);
      for (int i = 0; i < n_valid; i++) begin
         while ($urandom_range(0, 7) == 0) send_item(missing_power(), 1'b0);
         send_item(valid_power(), (i == n_valid - 1) && !tail_missing);
      end
      if (tail_missing) send_item(missing_power(), 1'b1);
   endtask

   initial begin : rsp_side
      int stall;
      wait (!reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end
         stall = draw_gap(rsp_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         ledger.match_result(rsp_weighted_power, rsp_no_average, rsp_sum_saturated);
      end
   end

   initial begin : req_side
      int len;
      int eff;
      int warm;
      int rides;
      int n;
      int sel;
      int phase;
      int big_done;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_power = '0;
      req_end_of_ride  = 1'b0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ride of one missing sample at the reset settings
      send_item(MISSING_LOWEST, 1'b1);

      // unmapped indexes, then a one-sample window with no warmup
      quiesce();
      csr_write(CSR_RSVD_LO, '1, 1'b0);
      csr_write(CSR_RSVD_HI, '0, 1'b0);
      program_regs(CFG_W'(0), CFG_W'(0));
      send_item(SAMPLE_W'(POWER_MAX), 1'b0);
      send_item('0, 1'b0);
      send_item(MISSING_ONE, 1'b0);
      send_item(SAMPLE_W'(POWER_MAX), 1'b1);

      // rounding of the window average, half up
      quiesce();
      program_regs(CFG_W'(2), CFG_W'(1));
      send_item(SAMPLE_W'(POWER_MAX), 1'b0);
      send_item(SAMPLE_W'(POWER_MAX - 1), 1'b0);
      send_item(SAMPLE_W'(1), 1'b0);
      send_item('0, 1'b1);

      // oversized window and longest warmup: no average in a short ride
      quiesce();
      program_regs('1, '1);
      send_item(SAMPLE_W'(POWER_MAX), 1'b0);
      send_item(SAMPLE_W'(17), 1'b0);
      send_item('0, 1'b1);

      // window shrunk mid-ride with the write index beyond the new length;
      // the oversized average also drives the root to its ceiling
      quiesce();
      program_regs(CFG_W'(6), CFG_W'(5));
      repeat (10) send_item(SAMPLE_W'(POWER_MAX), 1'b0);
      quiesce();
      program_regs(CFG_W'(2), CFG_W'(5));
      send_item(SAMPLE_W'(POWER_MAX), 1'b0);
      send_item(SAMPLE_W'(POWER_MAX), 1'b1);

      items_sent = 0;
      phase      = 0;
      big_done   = 0;
      while (items_sent < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 11);
         if (phase != HOLD_PHASE && sel == 0 && big_done < 2) begin
            len   = $urandom_range(200, 511);
            eff   = (len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : len;
            warm  = eff - 1 + $urandom_range(0, 3);
            rides = 1;
            big_done++;
         end else if (phase != HOLD_PHASE && sel == 1) begin
            len   = $urandom_range(0, 511);
            warm  = $urandom_range(300, 511);
            rides = $urandom_range(1, 3);
         end else begin
            len   = $urandom_range(0, 16);
            eff   = (len == 0) ? 1 : len;
            warm  = eff - 1 + $urandom_range(0, 8);
            rides = (phase == HOLD_PHASE) ? 6 : $urandom_range(1, 4);
         end
         quiesce();
         program_regs(CFG_W'(len), CFG_W'(warm));
         // receiver stops taking results while several short rides queue up
         if (phase == HOLD_PHASE) hold_off = 1'b1;
         for (int i = 0; i < rides; i++) begin
            if (phase == HOLD_PHASE)
               n = $urandom_range(0, 2);
            else if (warm >= 300 || $urandom_range(0, 4) == 0)
               n = $urandom_range(0, (warm < 12) ? warm : 12);
            else
               n = warm + 1 + $urandom_range(0, 12);
            run_ride(n);
         end
         phase++;
      end

      quiesce();
      if (ledger.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
design/rpfm_pkg.sv
design/rolling_power_fourth_mean.sv
design/rpfm_checker.sv
tb/tb_rolling_power_fourth_mean.sv
